// ===== design/stb_pkg.sv =====
// shared types and constants for the soft timer bank
package stb_pkg;

	// request codes on req_type
	localparam logic [2:0] REQ_TICK     = 3'd0;
	localparam logic [2:0] REQ_ADD_PER  = 3'd1;
	localparam logic [2:0] REQ_ADD_ONE  = 3'd2;
	localparam logic [2:0] REQ_REMOVE   = 3'd3;
	localparam logic [2:0] REQ_RESCHED  = 3'd4;
	localparam logic [2:0] REQ_SET_FACT = 3'd5;

	// ticks per uptime second
	localparam int SECOND_TICKS = 1000;
	localparam int SUB_W        = 10;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// classified command kinds
	typedef enum logic [2:0] {
		CMD_TICK,
		CMD_ADD,
		CMD_REMOVE,
		CMD_RESCHED,
		CMD_SET_FACT,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic        one_shot;
		logic [2:0]  slot;
		logic [31:0] delay_ms;
		logic [31:0] seconds_value;
	} cmd_t;

	// back end sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINAL
	} back_state_t;

endpackage

// ===== design/soft_timer_bank.sv =====
// top level of the soft timer bank
//
// A bank of NUM_SLOTS timers driven by a millisecond tick request.
// Requests come in on start/busy: a beat is taken at a clock edge with
// start high and busy low. req_type selects tick, add periodic, add
// one-shot, remove, reschedule or set factory seconds.
// Results leave on result_valid, one beat per cycle, and cannot be held off.
// A tick gives one beat per fired slot in ascending slot order, then a
// final beat with last high; every other request gives one beat with last.
// With the back end free, a non-tick result passes through the command queue
// and the result register to the ports; a tick's fire beats come from the
// deadline compare, which visits one slot per cycle, and its final beat
// follows the last slot. The back end takes the next command straight after
// a non-tick request, but a tick holds it until its final beat.
// A two-entry command queue sits in front and busy rises when both entries
// are full; a tick leaves the queue as its scan begins.
// Reset clears the queue, disarms all slots and sets the millisecond and
// uptime counts to 1 and the factory offset to 0.
module soft_timer_bank #(
	parameter int NUM_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [2:0]  slot,
	input  logic [31:0] delay_ms,
	input  logic [31:0] seconds_value,
	output logic        result_valid,
	output logic        fired,
	output logic [2:0]  fired_slot,
	output logic        ok,
	output logic [31:0] millis_now,
	output logic [31:0] uptime_seconds,
	output logic [31:0] factory_seconds,
	output logic        last
);

	logic          q_valid;
	logic          q_pop;
	stb_pkg::cmd_t q_cmd;

	// request decode and queue
	stb_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.slot          (slot),
		.delay_ms      (delay_ms),
		.seconds_value (seconds_value),
		.q_valid       (q_valid),
		.q_cmd         (q_cmd),
		.q_pop         (q_pop)
	);

	// execution and slot scan
	stb_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_cmd           (q_cmd),
		.q_pop           (q_pop),
		.result_valid    (result_valid),
		.fired           (fired),
		.fired_slot      (fired_slot),
		.ok              (ok),
		.millis_now      (millis_now),
		.uptime_seconds  (uptime_seconds),
		.factory_seconds (factory_seconds),
		.last            (last)
	);

endmodule

// ===== design/stb_front.sv =====
// front end: classifies requests and queues them for the back end
module stb_front #(
	parameter int NUM_SLOTS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        req_type,
	input  logic [2:0]        slot,
	input  logic [31:0]       delay_ms,
	input  logic [31:0]       seconds_value,
	output logic              q_valid,
	output stb_pkg::cmd_t     q_cmd,
	input  logic              q_pop
);

	stb_pkg::cmd_t                cmd_in;
	logic                         slot_in_range;
	logic                         push;
	logic                         pop;
	stb_pkg::cmd_t                mem_q [stb_pkg::QUEUE_DEPTH];
	logic [stb_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [stb_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [stb_pkg::QCNT_W-1:0]   cnt_q;

	// classify the incoming beat
	assign slot_in_range = 32'(slot) < NUM_SLOTS;

	always_comb begin
		cmd_in.kind          = stb_pkg::CMD_NOP;
		cmd_in.one_shot      = 1'b0;
		cmd_in.slot          = slot;
		cmd_in.delay_ms      = delay_ms;
		cmd_in.seconds_value = seconds_value;
		case (req_type)
			stb_pkg::REQ_TICK: begin
				cmd_in.kind = stb_pkg::CMD_TICK;
			end
			stb_pkg::REQ_ADD_PER: begin
				if (slot_in_range) cmd_in.kind = stb_pkg::CMD_ADD;
			end
			stb_pkg::REQ_ADD_ONE: begin
				if (slot_in_range) cmd_in.kind = stb_pkg::CMD_ADD;
				cmd_in.one_shot = 1'b1;
			end
			stb_pkg::REQ_REMOVE: begin
				if (slot_in_range) cmd_in.kind = stb_pkg::CMD_REMOVE;
			end
			stb_pkg::REQ_RESCHED: begin
				if (slot_in_range) cmd_in.kind = stb_pkg::CMD_RESCHED;
			end
			stb_pkg::REQ_SET_FACT: begin
				cmd_in.kind = stb_pkg::CMD_SET_FACT;
			end
			default: begin
				cmd_in.kind = stb_pkg::CMD_NOP;
			end
		endcase
	end

	// queue handshake
	assign busy    = cnt_q == stb_pkg::QCNT_W'(stb_pkg::QUEUE_DEPTH);
	assign push    = start && !busy;
	assign q_valid = cnt_q != '0;
	assign pop     = q_pop && q_valid;
	assign q_cmd   = mem_q[rd_ptr_q];

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= cmd_in;
	end

endmodule

// ===== design/stb_back.sv =====
// back end: keeps the counters and slots, executes commands, scans on ticks
module stb_back #(
	parameter int NUM_SLOTS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  stb_pkg::cmd_t     q_cmd,
	output logic              q_pop,
	output logic              result_valid,
	output logic              fired,
	output logic [2:0]        fired_slot,
	output logic              ok,
	output logic [31:0]       millis_now,
	output logic [31:0]       uptime_seconds,
	output logic [31:0]       factory_seconds,
	output logic              last
);

	localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SLOT_EXT_W = SLOT_W + 3;

	stb_pkg::back_state_t state_q, state_d;
	logic [SLOT_W-1:0]    scan_idx_q;
	logic [SLOT_W-1:0]    cmd_idx;
	logic [SLOT_EXT_W-1:0] cmd_slot_ext;
	logic [SLOT_EXT_W-1:0] scan_slot_ext;
	logic                 scan_last;

	logic [31:0]          ms_q;
	logic [stb_pkg::SUB_W-1:0] sub_q;
	logic [31:0]          up_q;
	logic [31:0]          off_q;
	logic [31:0]          ms_d;
	logic [stb_pkg::SUB_W:0] sub_inc;
	logic                 roll;
	logic [31:0]          up_d;
	logic [31:0]          off_d;

	logic [NUM_SLOTS-1:0] armed_q;
	logic [NUM_SLOTS-1:0] done_q;
	logic [NUM_SLOTS-1:0] one_shot_q;
	logic [31:0]          deadline_q [NUM_SLOTS];
	logic [31:0]          period_q [NUM_SLOTS];

	logic                 fire_hit;
	logic                 cmd_ok;
	logic                 do_tick;
	logic                 do_cmd;
	logic                 do_fire;
	logic                 emit;
	logic                 e_fired;
	logic                 e_ok;
	logic                 e_last;

	// slot indexes
	assign cmd_slot_ext  = SLOT_EXT_W'(q_cmd.slot);
	assign cmd_idx       = cmd_slot_ext[SLOT_W-1:0];
	assign scan_slot_ext = SLOT_EXT_W'(scan_idx_q);
	assign scan_last     = scan_idx_q == SLOT_W'(NUM_SLOTS - 1);

	// slot under scan is due
	assign fire_hit = armed_q[scan_idx_q] && !done_q[scan_idx_q]
		&& (deadline_q[scan_idx_q] <= ms_q);

	// command status
	always_comb begin
		case (q_cmd.kind)
			stb_pkg::CMD_ADD:      cmd_ok = 1'b1;
			stb_pkg::CMD_RESCHED:  cmd_ok = 1'b1;
			stb_pkg::CMD_SET_FACT: cmd_ok = 1'b1;
			stb_pkg::CMD_TICK:     cmd_ok = 1'b1;
			stb_pkg::CMD_REMOVE:   cmd_ok = armed_q[cmd_idx];
			default:               cmd_ok = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			stb_pkg::ST_IDLE: begin
				if (q_valid && q_cmd.kind == stb_pkg::CMD_TICK) state_d = stb_pkg::ST_SCAN;
			end
			stb_pkg::ST_SCAN: begin
				if (scan_last) state_d = stb_pkg::ST_FINAL;
			end
			stb_pkg::ST_FINAL: begin
				state_d = stb_pkg::ST_IDLE;
			end
			default: begin
				state_d = stb_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		q_pop   = 1'b0;
		do_tick = 1'b0;
		do_cmd  = 1'b0;
		do_fire = 1'b0;
		emit    = 1'b0;
		e_fired = 1'b0;
		e_ok    = 1'b0;
		e_last  = 1'b0;
		case (state_q)
			stb_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_cmd.kind == stb_pkg::CMD_TICK) begin
						do_tick = 1'b1;
					end else begin
						do_cmd = 1'b1;
						emit   = 1'b1;
						e_ok   = cmd_ok;
						e_last = 1'b1;
					end
				end
			end
			stb_pkg::ST_SCAN: begin
				if (fire_hit) begin
					do_fire = 1'b1;
					emit    = 1'b1;
					e_fired = 1'b1;
					e_ok    = 1'b1;
				end
			end
			stb_pkg::ST_FINAL: begin
				emit   = 1'b1;
				e_ok   = 1'b1;
				e_last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// counter next values
	assign ms_d    = do_tick ? ms_q + 32'd1 : ms_q;
	assign sub_inc = {1'b0, sub_q} + 1'b1;
	assign roll    = do_tick && (sub_inc >= (stb_pkg::SUB_W + 1)'(stb_pkg::SECOND_TICKS));
	assign up_d    = roll ? up_q + 32'd1 : up_q;
	assign off_d   = (do_cmd && q_cmd.kind == stb_pkg::CMD_SET_FACT)
		? q_cmd.seconds_value - up_q : off_q;

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= stb_pkg::ST_IDLE;
			scan_idx_q <= '0;
			ms_q       <= 32'd1;
			sub_q      <= '0;
			up_q       <= 32'd1;
			off_q      <= '0;
		end else begin
			state_q <= state_d;
			if (do_tick) scan_idx_q <= '0;
			else if (state_q == stb_pkg::ST_SCAN && !scan_last) scan_idx_q <= scan_idx_q + 1'b1;
			ms_q  <= ms_d;
			off_q <= off_d;
			up_q  <= up_d;
			if (do_tick) sub_q <= roll ? '0 : sub_inc[stb_pkg::SUB_W-1:0];
		end
	end

	// slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q    <= '0;
			done_q     <= '0;
			one_shot_q <= '0;
		end else begin
			if (do_cmd) begin
				case (q_cmd.kind)
					stb_pkg::CMD_ADD: begin
						armed_q[cmd_idx]    <= 1'b1;
						done_q[cmd_idx]     <= 1'b0;
						one_shot_q[cmd_idx] <= q_cmd.one_shot;
					end
					stb_pkg::CMD_REMOVE: begin
						armed_q[cmd_idx] <= 1'b0;
					end
					stb_pkg::CMD_RESCHED: begin
						done_q[cmd_idx] <= 1'b0;
					end
					default: begin
						armed_q <= armed_q;
					end
				endcase
			end
			if (do_fire && one_shot_q[scan_idx_q]) done_q[scan_idx_q] <= 1'b1;
		end
	end

	// slot deadlines and periods
	always_ff @(posedge clk) begin
		if (do_cmd && q_cmd.kind == stb_pkg::CMD_ADD) begin
			deadline_q[cmd_idx] <= ms_q + q_cmd.delay_ms;
			period_q[cmd_idx]   <= q_cmd.delay_ms;
		end else if (do_cmd && q_cmd.kind == stb_pkg::CMD_RESCHED) begin
			deadline_q[cmd_idx] <= q_cmd.delay_ms + ms_q;
		end
		if (do_fire && !one_shot_q[scan_idx_q]) begin
			deadline_q[scan_idx_q] <= period_q[scan_idx_q] + ms_q;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= emit;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			fired           <= e_fired;
			fired_slot      <= e_fired ? scan_slot_ext[2:0] : 3'd0;
			ok              <= e_ok;
			last            <= e_last;
			millis_now      <= ms_d;
			uptime_seconds  <= up_d;
			factory_seconds <= up_d + off_d;
		end
	end

endmodule

// ===== design/stb_checker.sv =====
// port-level checks for the soft timer bank
module stb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [2:0]  req_type,
	input logic [2:0]  slot,
	input logic [31:0] delay_ms,
	input logic [31:0] seconds_value,
	input logic        result_valid,
	input logic        fired,
	input logic [2:0]  fired_slot,
	input logic        ok,
	input logic [31:0] millis_now,
	input logic [31:0] uptime_seconds,
	input logic [31:0] factory_seconds,
	input logic        last
);

	// a beat that is not the final one reports a fire
	a_nonlast_fires: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> fired && ok)
		else $error("non-final result beat without a fire");

	// a final beat never carries a fire or a slot
	a_last_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !fired && fired_slot == 3'd0)
		else $error("final result beat carries a fire");

	// fires of one tick come in ascending slot order
	a_fire_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && fired && $past(result_valid) && $past(fired)
		|-> fired_slot > $past(fired_slot))
		else $error("fires out of slot order");

	// beats of one tick carry the same counters
	a_tick_counters: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(result_valid) && !$past(last)
		|-> millis_now == $past(millis_now) && uptime_seconds == $past(uptime_seconds))
		else $error("counters moved within one tick");

endmodule

bind soft_timer_bank stb_checker u_stb_checker (.*);

// ===== tb/tb_top.sv =====
// self-checking testbench for soft_timer_bank: directed and random timer requests
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SLOTS    = 8;
	localparam int RANDOM_ITEMS = 455;
	localparam int TAIL_CYCLES  = NUM_SLOTS + 8;

	// request codes the block does not decode
	localparam logic [2:0] REQ_BAD_LO = 3'd6;
	localparam logic [2:0] REQ_BAD_HI = 3'd7;

	typedef struct {
		logic [2:0]  req_type;
		logic [2:0]  slot;
		logic [31:0] delay_ms;
		logic [31:0] seconds_value;
		bit          hold;
	} timer_req_t;

	typedef struct {
		logic        fired;
		logic [2:0]  fired_slot;
		logic        ok;
		logic [31:0] millis_now;
		logic [31:0] uptime_seconds;
		logic [31:0] factory_seconds;
		logic        last;
	} timer_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  req_type = '0;
	logic [2:0]  slot = '0;
	logic [31:0] delay_ms = '0;
	logic [31:0] seconds_value = '0;
	logic        busy;
	logic        result_valid;
	logic        fired;
	logic [2:0]  fired_slot;
	logic        ok;
	logic [31:0] millis_now;
	logic [31:0] uptime_seconds;
	logic [31:0] factory_seconds;
	logic        last;

	// stimulus and expected beats
	timer_req_t    request_q[$];
	timer_result_t pending_results[$];

	// timer bank state as the block should hold it
	logic [31:0] ms_cnt;
	logic [31:0] up_secs;
	logic [31:0] fact_offset;
	int          sub_ticks;
	logic [31:0] deadline[NUM_SLOTS];
	logic [31:0] period[NUM_SLOTS];
	bit          one_shot[NUM_SLOTS];
	bit          armed[NUM_SLOTS];
	bit          expired[NUM_SLOTS];

	// sender and bookkeeping
	bit beat_taken = 1'b0;
	bit draining = 1'b0;
	bit stim_done = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int n_errors = 0;
	int n_accepted = 0;
	int n_ticks = 0;
	int n_fires = 0;
	int n_results = 0;

	soft_timer_bank #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.slot           (slot),
		.delay_ms       (delay_ms),
		.seconds_value  (seconds_value),
		.result_valid   (result_valid),
		.fired          (fired),
		.fired_slot     (fired_slot),
		.ok             (ok),
		.millis_now     (millis_now),
		.uptime_seconds (uptime_seconds),
		.factory_seconds(factory_seconds),
		.last           (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void push_req(logic [2:0] kind, logic [2:0] s, logic [31:0] dly,
			logic [31:0] secs);
		timer_req_t r;
		r.req_type      = kind;
		r.slot          = s;
		r.delay_ms      = dly;
		r.seconds_value = secs;
		r.hold          = 1'b0;
		request_q.push_back(r);
	endfunction

	// sender waits here until every expected beat has come back
	function automatic void push_hold();
		timer_req_t r;
		r.req_type      = stb_pkg::REQ_TICK;
		r.slot          = '0;
		r.delay_ms      = '0;
		r.seconds_value = '0;
		r.hold          = 1'b1;
		request_q.push_back(r);
	endfunction

	function automatic void push_result(logic f, logic [2:0] s, logic k, logic l);
		timer_result_t r;
		r.fired           = f;
		r.fired_slot      = f ? s : 3'd0;
		r.ok              = k;
		r.millis_now      = ms_cnt;
		r.uptime_seconds  = up_secs;
		r.factory_seconds = up_secs + fact_offset;
		r.last            = l;
		pending_results.push_back(r);
	endfunction

	// advance the timer bank by one request and queue the beats it must produce
	function automatic void predict_timer_results(timer_req_t r);
		logic [2:0] fire_list[$];
		logic       granted;
		int         i;
		granted = 1'b0;
		if (r.req_type == stb_pkg::REQ_TICK) begin
			n_ticks++;
			ms_cnt = ms_cnt + 32'd1;
			sub_ticks++;
			for (i = 0; i < NUM_SLOTS; i++) begin
				if (armed[i] && !expired[i] && deadline[i] <= ms_cnt) begin
					fire_list.push_back(3'(i));
					if (one_shot[i])
						expired[i] = 1'b1;
					else
						deadline[i] = period[i] + ms_cnt;
				end
			end
			// seconds rollover lands before any beat goes out
			if (sub_ticks >= stb_pkg::SECOND_TICKS) begin
				sub_ticks = 0;
				up_secs   = up_secs + 32'd1;
			end
			foreach (fire_list[j])
				push_result(1'b1, fire_list[j], 1'b1, 1'b0);
			n_fires += fire_list.size();
			push_result(1'b0, 3'd0, 1'b1, 1'b1);
		end else begin
			case (r.req_type)
				stb_pkg::REQ_ADD_PER, stb_pkg::REQ_ADD_ONE: begin
					if (r.slot < NUM_SLOTS) begin
						deadline[r.slot] = ms_cnt + r.delay_ms;
						period[r.slot]   = r.delay_ms;
						one_shot[r.slot] = (r.req_type == stb_pkg::REQ_ADD_ONE);
						armed[r.slot]    = 1'b1;
						expired[r.slot]  = 1'b0;
						granted          = 1'b1;
					end
				end
				stb_pkg::REQ_REMOVE: begin
					if (r.slot < NUM_SLOTS) begin
						granted       = armed[r.slot];
						armed[r.slot] = 1'b0;
					end
				end
				stb_pkg::REQ_RESCHED: begin
					// an unarmed slot keeps the new deadline but stays unarmed
					if (r.slot < NUM_SLOTS) begin
						deadline[r.slot] = r.delay_ms + ms_cnt;
						expired[r.slot]  = 1'b0;
						granted          = 1'b1;
					end
				end
				stb_pkg::REQ_SET_FACT: begin
					fact_offset = r.seconds_value - up_secs;
					granted     = 1'b1;
				end
				default: begin
					granted = 1'b0;
				end
			endcase
			push_result(1'b0, 3'd0, granted, 1'b1);
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			n_errors++;
		end
	endfunction

	// monitor: check result beats, predict on every accepted request beat
	always @(posedge clk) begin
		timer_result_t want;
		timer_req_t    got_req;
		if (arst_n) begin
			if (result_valid) begin
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected: fired %0b slot %0d last %0b",
						fired, fired_slot, last);
					n_errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("fired", 32'(want.fired), 32'(fired));
					check_field("fired_slot", 32'(want.fired_slot), 32'(fired_slot));
					check_field("ok", 32'(want.ok), 32'(ok));
					check_field("millis_now", want.millis_now, millis_now);
					check_field("uptime_seconds", want.uptime_seconds, uptime_seconds);
					check_field("factory_seconds", want.factory_seconds, factory_seconds);
					check_field("last", 32'(want.last), 32'(last));
					n_results++;
				end
			end
			if (start && !busy) begin
				got_req.req_type      = req_type;
				got_req.slot          = slot;
				got_req.delay_ms      = delay_ms;
				got_req.seconds_value = seconds_value;
				got_req.hold          = 1'b0;
				predict_timer_results(got_req);
				beat_taken = 1'b1;
				n_accepted++;
			end
		end
	end

	// driver: bursts of request beats with random gaps, changed on the falling edge
	always @(negedge clk) begin
		timer_req_t nxt;
		int         pick;
		if (arst_n && !(start && !beat_taken)) begin
			beat_taken = 1'b0;
			if (draining) begin
				if (pending_results.size() == 0)
					draining = 1'b0;
				start <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				start         <= 1'b0;
				req_type      <= 3'($urandom_range(0, 7));
				slot          <= 3'($urandom_range(0, 7));
				delay_ms      <= $urandom;
				seconds_value <= $urandom;
			end else if (request_q.size() > 0) begin
				nxt = request_q.pop_front();
				if (nxt.hold) begin
					draining = 1'b1;
					start <= 1'b0;
				end else begin
					req_type      <= nxt.req_type;
					slot          <= nxt.slot;
					delay_ms      <= nxt.delay_ms;
					seconds_value <= nxt.seconds_value;
					start         <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						pick       = $urandom_range(0, 3);
						if (pick == 0)
							gap_left = 0;
						else if (pick < 3)
							gap_left = $urandom_range(1, 4);
						else
							gap_left = $urandom_range(5, 24);
					end else begin
						burst_left--;
					end
				end
			end else begin
				start <= 1'b0;
				stim_done = 1'b1;
			end
		end
	end

	// run control: stimulus, reset, drain and verdict
	initial begin
		int          i;
		int          n;
		int          pick;
		logic [2:0]  kind;
		logic [31:0] dly;

		ms_cnt      = 32'd1;
		up_secs     = 32'd1;
		fact_offset = 32'd0;
		sub_ticks   = 0;
		for (i = 0; i < NUM_SLOTS; i++) begin
			deadline[i] = '0;
			period[i]   = '0;
			one_shot[i] = 1'b0;
			armed[i]    = 1'b0;
			expired[i]  = 1'b0;
		end

		// directed: extremes, every request kind and the corner cases
		push_req(stb_pkg::REQ_TICK, 3'd0, 32'd0, 32'd0);
		push_req(stb_pkg::REQ_ADD_PER, 3'd0, 32'd0, 32'hFFFF_FFFF);
		push_req(stb_pkg::REQ_ADD_ONE, 3'd7, 32'd2, 32'd0);
		push_req(stb_pkg::REQ_ADD_PER, 3'd3, 32'hFFFF_FFFF, 32'd0);
		push_req(stb_pkg::REQ_ADD_ONE, 3'd5, 32'hFFFF_FFFE, 32'd0);
		push_req(stb_pkg::REQ_TICK, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_req(stb_pkg::REQ_TICK, 3'd0, 32'd0, 32'd0);
		push_req(stb_pkg::REQ_TICK, 3'd0, 32'd0, 32'd0);
		push_req(stb_pkg::REQ_RESCHED, 3'd7, 32'd1, 32'd0);
		push_req(stb_pkg::REQ_TICK, 3'd0, 32'd0, 32'd0);
		push_req(stb_pkg::REQ_REMOVE, 3'd6, 32'd0, 32'd0);
		push_req(stb_pkg::REQ_REMOVE, 3'd0, 32'd0, 32'd0);
		push_req(stb_pkg::REQ_RESCHED, 3'd6, 32'd0, 32'd0);
		push_req(stb_pkg::REQ_TICK, 3'd0, 32'd0, 32'd0);
		push_req(stb_pkg::REQ_ADD_PER, 3'd3, 32'd1, 32'd0);
		push_req(stb_pkg::REQ_SET_FACT, 3'd0, 32'd0, 32'hFFFF_FFFF);
		push_req(stb_pkg::REQ_SET_FACT, 3'd7, 32'hFFFF_FFFF, 32'd0);
		push_req(REQ_BAD_LO, 3'd2, 32'd5, 32'h1234_5678);
		push_req(REQ_BAD_HI, 3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_req(stb_pkg::REQ_ADD_PER, 3'd1, 32'd0, 32'd0);
		push_req(stb_pkg::REQ_ADD_PER, 3'd2, 32'd0, 32'd0);
		push_req(stb_pkg::REQ_ADD_PER, 3'd4, 32'd0, 32'd0);
		push_req(stb_pkg::REQ_ADD_PER, 3'd6, 32'd0, 32'd0);
		push_req(stb_pkg::REQ_ADD_ONE, 3'd5, 32'd0, 32'd0);
		push_req(stb_pkg::REQ_TICK, 3'd0, 32'd0, 32'd0);
		push_hold();

		// random mix, weighted toward ticks and short delays so slots keep firing
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				kind = stb_pkg::REQ_TICK;
			else if (pick < 57)
				kind = stb_pkg::REQ_ADD_PER;
			else if (pick < 67)
				kind = stb_pkg::REQ_ADD_ONE;
			else if (pick < 76)
				kind = stb_pkg::REQ_REMOVE;
			else if (pick < 86)
				kind = stb_pkg::REQ_RESCHED;
			else if (pick < 94)
				kind = stb_pkg::REQ_SET_FACT;
			else if (pick < 97)
				kind = REQ_BAD_LO;
			else
				kind = REQ_BAD_HI;
			pick = $urandom_range(0, 99);
			if (pick < 65)
				dly = $urandom_range(0, 12);
			else if (pick < 80)
				dly = $urandom_range(13, 300);
			else if (pick < 90)
				dly = 32'hFFFF_FFFF - $urandom_range(0, 20);
			else
				dly = $urandom;
			push_req(kind, 3'($urandom_range(0, 7)), dly, $urandom);
			if ($urandom_range(0, 59) == 0)
				push_hold();
		end
		push_hold();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!stim_done)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (pending_results.size() != 0) begin
			$error("%0d result beats never arrived", pending_results.size());
			n_errors++;
		end
		$display("run covered %0d requests, %0d of them ticks, with %0d slot expiries",
			n_accepted, n_ticks, n_fires);
		$display("%0d result beats checked; uptime reached %0d s at %0d ms",
			n_results, up_secs, ms_cnt);
		if (n_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("timeout with %0d requests queued and %0d beats expected",
			request_q.size(), pending_results.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
